>>> src/cau_pkg.sv
// Shared opcode type for the complex arithmetic unit.
package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4,
        OP_NEG = 3'd5,
        OP_INC = 3'd6,
        OP_DEC = 3'd7
    } op_t;

endpackage

>>> src/cau_in_if.sv
// Operand channel: opcode and two complex operands with a valid/ready handshake.
interface cau_in_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   opcode;
    logic signed [DATA_WIDTH-1:0] a_real;
    logic signed [DATA_WIDTH-1:0] a_imag;
    logic signed [DATA_WIDTH-1:0] b_real;
    logic signed [DATA_WIDTH-1:0] b_imag;

    modport source (output valid, opcode, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, opcode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

>>> src/cau_out_if.sv
// Result channel: one complex result and its flags with a valid/ready handshake.
interface cau_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_real;
    logic signed [DATA_WIDTH-1:0] res_imag;
    logic                         saturated;
    logic                         div_by_zero;

    modport source (output valid, res_real, res_imag, saturated, div_by_zero, input ready);
    modport sink   (input valid, res_real, res_imag, saturated, div_by_zero, output ready);
endinterface

>>> src/cau_step.sv
// One quotient bit of both divides and one root bit of the square root.
module cau_step #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int IDX        = 0
) (
    input  logic [2*DATA_WIDTH-1:0]           d,
    input  logic [2*DATA_WIDTH+FRAC_BITS-1:0] cur_rem_re,
    input  logic [2*DATA_WIDTH+FRAC_BITS-1:0] cur_rem_im,
    input  logic [DATA_WIDTH-1:0]             cur_q_re,
    input  logic [DATA_WIDTH-1:0]             cur_q_im,
    input  logic [2*DATA_WIDTH-1:0]           cur_srem,
    input  logic [DATA_WIDTH-1:0]             cur_root,
    output logic [2*DATA_WIDTH+FRAC_BITS-1:0] new_rem_re,
    output logic [2*DATA_WIDTH+FRAC_BITS-1:0] new_rem_im,
    output logic [DATA_WIDTH-1:0]             new_q_re,
    output logic [DATA_WIDTH-1:0]             new_q_im,
    output logic [2*DATA_WIDTH-1:0]           new_srem,
    output logic [DATA_WIDTH-1:0]             new_root
);
    localparam int NW = 2*DATA_WIDTH + FRAC_BITS;
    localparam int CW = 3*DATA_WIDTH + FRAC_BITS;
    localparam int SW = 2*DATA_WIDTH + 1;

    logic [CW-1:0] dsh;
    logic [SW-1:0] trial;

    always_comb
    begin
        dsh   = CW'(d) << IDX;
        trial = (SW'(cur_root) << (IDX + 1)) + (SW'(1) << (2*IDX));

        new_rem_re = cur_rem_re;
        new_q_re   = cur_q_re;
        if (CW'(cur_rem_re) >= dsh)
        begin
            new_rem_re    = cur_rem_re - dsh[NW-1:0];
            new_q_re[IDX] = 1'b1;
        end

        new_rem_im = cur_rem_im;
        new_q_im   = cur_q_im;
        if (CW'(cur_rem_im) >= dsh)
        begin
            new_rem_im    = cur_rem_im - dsh[NW-1:0];
            new_q_im[IDX] = 1'b1;
        end

        // Try the next root bit: (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i).
        new_srem = cur_srem;
        new_root = cur_root;
        if (SW'(cur_srem) >= trial)
        begin
            new_srem      = cur_srem - trial[2*DATA_WIDTH-1:0];
            new_root[IDX] = 1'b1;
        end
    end
endmodule

>>> src/complex_arithmetic_unit_top.sv
// Top level of the complex arithmetic unit: a fully pipelined complex ALU.
//
// Usage: an item on the operand channel carries an opcode and two complex
// operands a and b, each component signed fixed point with FRAC_BITS
// fractional bits. The result channel returns one item per operand item, in
// order: the saturated complex result, a flag that is set when either
// component was clipped, and a flag for a divide by a zero operand.
//
// The pipeline has DATA_WIDTH + 6 register stages. The first stage is loaded
// at the edge that accepts an item, and the last stage drives the result
// channel. The depth is set by the divide and the square root, which resolve
// one quotient bit and one root bit per stage. A new item is accepted in every
// cycle while the receiver does not stall a result, so the sustained rate is
// one item per cycle.
//
// When the receiver stalls a valid result, the whole pipeline holds in place
// and operand ready drops in the same cycle; nothing is lost or repeated.
// Reset clears only the valid bits of the stages; the block keeps no other
// state.
module complex_arithmetic_unit_top #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input logic clk,
    input logic rst_n,
    cau_in_if.sink    operand,
    cau_out_if.source result
);
    localparam int W  = DATA_WIDTH;
    localparam int NW = 2*W + FRAC_BITS;
    localparam int CW = 3*W + FRAC_BITS;
    localparam int RW = 2*W + 2;

    localparam logic signed [RW-1:0] VMAX_R = $signed((RW'(1) << (W-1)) - RW'(1));
    localparam logic signed [RW-1:0] VMIN_R = -VMAX_R - RW'(1);
    localparam logic signed [RW-1:0] ONE_R  = $signed(RW'(1) << FRAC_BITS);

    typedef struct packed {
        cau_pkg::op_t        op;
        logic signed [W-1:0] ar;
        logic signed [W-1:0] ai;
        logic signed [W-1:0] br;
        logic signed [W-1:0] bi;
    } sa_t;

    typedef struct packed {
        cau_pkg::op_t          op;
        logic signed [2*W-1:0] prr;
        logic signed [2*W-1:0] pii;
        logic signed [2*W-1:0] pir;
        logic signed [2*W-1:0] pri;
        logic signed [2*W-1:0] paa;
        logic signed [2*W-1:0] pbb;
        logic signed [2*W-1:0] pdr;
        logic signed [2*W-1:0] pdi;
        logic signed [RW-1:0]  sre;
        logic signed [RW-1:0]  sim;
    } sb_t;

    typedef struct packed {
        cau_pkg::op_t         op;
        logic signed [RW-1:0] sre;
        logic signed [RW-1:0] sim;
        logic signed [2*W:0]  nre;
        logic signed [2*W:0]  nim;
        logic [2*W-1:0]       d;
        logic [2*W-1:0]       x;
    } sc_t;

    typedef struct packed {
        cau_pkg::op_t         op;
        logic signed [RW-1:0] sre;
        logic signed [RW-1:0] sim;
        logic                 dz;
        logic                 neg_re;
        logic                 neg_im;
        logic [2*W-1:0]       d;
        logic [2*W-1:0]       x;
        logic [NW-1:0]        nre;
        logic [NW-1:0]        nim;
    } sd_t;

    typedef struct packed {
        cau_pkg::op_t         op;
        logic signed [RW-1:0] sre;
        logic signed [RW-1:0] sim;
        logic                 dz;
        logic                 neg_re;
        logic                 neg_im;
        logic                 ovf_re;
        logic                 ovf_im;
        logic [2*W-1:0]       d;
        logic [NW-1:0]        rre;
        logic [NW-1:0]        rim;
        logic [W-1:0]         qre;
        logic [W-1:0]         qim;
        logic [2*W-1:0]       srem;
        logic [W-1:0]         root;
    } sp_t;

    // Clip to the signed output range; the top bit reports clipping.
    function automatic logic [W:0] clip(input logic signed [RW-1:0] v);
        logic [W:0] r;
        if (v > VMAX_R)
            r = {1'b1, VMAX_R[W-1:0]};
        else if (v < VMIN_R)
            r = {1'b1, VMIN_R[W-1:0]};
        else
            r = {1'b0, v[W-1:0]};
        return r;
    endfunction

    // Signed quotient; an overflowed magnitude is replaced by 2^W, which clips.
    function automatic logic signed [RW-1:0] quot(input logic ovf, input logic neg,
                                                 input logic [W-1:0] q);
        logic signed [RW-1:0] mag;
        mag = ovf ? $signed(RW'(1) << W) : $signed(RW'(q));
        return neg ? -mag : mag;
    endfunction

    logic en;

    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic [W:0] vp_reg;
    logic out_valid_reg;

    sa_t sa_reg, sa_next;
    sb_t sb_reg, sb_next;
    sc_t sc_reg, sc_next;
    sd_t sd_reg, sd_next;
    sp_t sp_reg [0:W];
    sp_t sp_next [0:W];

    logic signed [W-1:0] res_real_reg, res_real_next;
    logic signed [W-1:0] res_imag_reg, res_imag_next;
    logic                sat_reg, sat_next;
    logic                dz_reg, dz_next;

    // The pipeline advances as one whenever the output register is free.
    assign en            = !out_valid_reg || result.ready;
    assign operand.ready = en;

    always_comb
    begin
        sa_next.op = cau_pkg::op_t'(operand.opcode);
        sa_next.ar = operand.a_real;
        sa_next.ai = operand.a_imag;
        sa_next.br = operand.b_real;
        sa_next.bi = operand.b_imag;
    end

    // Products, plus the operations that need only an add.
    always_comb
    begin
        logic signed [RW-1:0] ar, ai, br, bi;
        ar = RW'(sa_reg.ar);
        ai = RW'(sa_reg.ai);
        br = RW'(sa_reg.br);
        bi = RW'(sa_reg.bi);
        sb_next.op  = sa_reg.op;
        sb_next.prr = sa_reg.ar * sa_reg.br;
        sb_next.pii = sa_reg.ai * sa_reg.bi;
        sb_next.pir = sa_reg.ai * sa_reg.br;
        sb_next.pri = sa_reg.ar * sa_reg.bi;
        sb_next.paa = sa_reg.ar * sa_reg.ar;
        sb_next.pbb = sa_reg.ai * sa_reg.ai;
        sb_next.pdr = sa_reg.br * sa_reg.br;
        sb_next.pdi = sa_reg.bi * sa_reg.bi;
        case (sa_reg.op)
            cau_pkg::OP_ADD:
            begin
                sb_next.sre = ar + br;
                sb_next.sim = ai + bi;
            end
            cau_pkg::OP_SUB:
            begin
                sb_next.sre = ar - br;
                sb_next.sim = ai - bi;
            end
            cau_pkg::OP_NEG:
            begin
                sb_next.sre = -ar;
                sb_next.sim = -ai;
            end
            cau_pkg::OP_INC:
            begin
                sb_next.sre = ar + ONE_R;
                sb_next.sim = ai;
            end
            cau_pkg::OP_DEC:
            begin
                sb_next.sre = ar - ONE_R;
                sb_next.sim = ai;
            end
            default:
            begin
                sb_next.sre = '0;
                sb_next.sim = '0;
            end
        endcase
    end

    // Sums of products; the multiply result is floored by an arithmetic shift.
    always_comb
    begin
        logic signed [2*W:0] mre, mim;
        mre = (2*W+1)'(sb_reg.prr) - (2*W+1)'(sb_reg.pii);
        mim = (2*W+1)'(sb_reg.pir) + (2*W+1)'(sb_reg.pri);
        sc_next.op  = sb_reg.op;
        sc_next.nre = (2*W+1)'(sb_reg.prr) + (2*W+1)'(sb_reg.pii);
        sc_next.nim = (2*W+1)'(sb_reg.pir) - (2*W+1)'(sb_reg.pri);
        sc_next.d   = $unsigned(sb_reg.pdr) + $unsigned(sb_reg.pdi);
        sc_next.x   = $unsigned(sb_reg.paa) + $unsigned(sb_reg.pbb);
        if (sb_reg.op == cau_pkg::OP_MUL)
        begin
            sc_next.sre = RW'(mre >>> FRAC_BITS);
            sc_next.sim = RW'(mim >>> FRAC_BITS);
        end
        else
        begin
            sc_next.sre = sb_reg.sre;
            sc_next.sim = sb_reg.sim;
        end
    end

    // Numerator magnitudes scaled by one, and their signs.
    always_comb
    begin
        logic signed [2*W:0] are, aim;
        are = (sc_reg.nre < 0) ? -sc_reg.nre : sc_reg.nre;
        aim = (sc_reg.nim < 0) ? -sc_reg.nim : sc_reg.nim;
        sd_next.op     = sc_reg.op;
        sd_next.sre    = sc_reg.sre;
        sd_next.sim    = sc_reg.sim;
        sd_next.dz     = (sc_reg.d == '0);
        sd_next.neg_re = (sc_reg.nre < 0);
        sd_next.neg_im = (sc_reg.nim < 0);
        sd_next.d      = sc_reg.d;
        sd_next.x      = sc_reg.x;
        sd_next.nre    = NW'(are[2*W-1:0]) << FRAC_BITS;
        sd_next.nim    = NW'(aim[2*W-1:0]) << FRAC_BITS;
    end

    // A quotient of 2^W or more cannot fit and is flagged before the bit steps.
    always_comb
    begin
        sp_next[0].op     = sd_reg.op;
        sp_next[0].sre    = sd_reg.sre;
        sp_next[0].sim    = sd_reg.sim;
        sp_next[0].dz     = sd_reg.dz;
        sp_next[0].neg_re = sd_reg.neg_re;
        sp_next[0].neg_im = sd_reg.neg_im;
        sp_next[0].ovf_re = CW'(sd_reg.nre) >= (CW'(sd_reg.d) << W);
        sp_next[0].ovf_im = CW'(sd_reg.nim) >= (CW'(sd_reg.d) << W);
        sp_next[0].d      = sd_reg.d;
        sp_next[0].rre    = sd_reg.nre;
        sp_next[0].rim    = sd_reg.nim;
        sp_next[0].qre    = '0;
        sp_next[0].qim    = '0;
        sp_next[0].srem   = sd_reg.x;
        sp_next[0].root   = '0;
    end

    for (genvar k = 1; k <= W; k++)
    begin : g_step
        always_comb
        begin
            sp_next[k].op     = sp_reg[k-1].op;
            sp_next[k].sre    = sp_reg[k-1].sre;
            sp_next[k].sim    = sp_reg[k-1].sim;
            sp_next[k].dz     = sp_reg[k-1].dz;
            sp_next[k].neg_re = sp_reg[k-1].neg_re;
            sp_next[k].neg_im = sp_reg[k-1].neg_im;
            sp_next[k].ovf_re = sp_reg[k-1].ovf_re;
            sp_next[k].ovf_im = sp_reg[k-1].ovf_im;
            sp_next[k].d      = sp_reg[k-1].d;
        end

        cau_step #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .IDX        (W - k)
        ) u_step (
            .d          (sp_reg[k-1].d),
            .cur_rem_re (sp_reg[k-1].rre),
            .cur_rem_im (sp_reg[k-1].rim),
            .cur_q_re   (sp_reg[k-1].qre),
            .cur_q_im   (sp_reg[k-1].qim),
            .cur_srem   (sp_reg[k-1].srem),
            .cur_root   (sp_reg[k-1].root),
            .new_rem_re (sp_next[k].rre),
            .new_rem_im (sp_next[k].rim),
            .new_q_re   (sp_next[k].qre),
            .new_q_im   (sp_next[k].qim),
            .new_srem   (sp_next[k].srem),
            .new_root   (sp_next[k].root)
        );
    end

    // Pick the result by opcode, then saturate both components.
    always_comb
    begin
        logic signed [RW-1:0] vre, vim;
        logic [W:0]           cre, cim;
        vre     = sp_reg[W].sre;
        vim     = sp_reg[W].sim;
        dz_next = 1'b0;
        case (sp_reg[W].op)
            cau_pkg::OP_DIV:
            begin
                if (sp_reg[W].dz)
                begin
                    vre     = '0;
                    vim     = '0;
                    dz_next = 1'b1;
                end
                else
                begin
                    vre = quot(sp_reg[W].ovf_re, sp_reg[W].neg_re, sp_reg[W].qre);
                    vim = quot(sp_reg[W].ovf_im, sp_reg[W].neg_im, sp_reg[W].qim);
                end
            end
            cau_pkg::OP_MAG:
            begin
                vre = $signed(RW'(sp_reg[W].root));
                vim = '0;
            end
            default:
            begin
                vre = sp_reg[W].sre;
                vim = sp_reg[W].sim;
            end
        endcase
        cre           = clip(vre);
        cim           = clip(vim);
        res_real_next = cre[W-1:0];
        res_imag_next = cim[W-1:0];
        sat_next      = cre[W] | cim[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            vp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg        <= operand.valid;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            vd_reg        <= vc_reg;
            vp_reg        <= {vp_reg[W-1:0], vd_reg};
            out_valid_reg <= vp_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg        <= sa_next;
            sb_reg        <= sb_next;
            sc_reg        <= sc_next;
            sd_reg        <= sd_next;
            res_real_reg  <= res_real_next;
            res_imag_reg  <= res_imag_next;
            sat_reg       <= sat_next;
            dz_reg        <= dz_next;
        end
    end

    for (genvar k = 0; k <= W; k++)
    begin : g_preg
        always_ff @(posedge clk)
        begin
            if (en)
                sp_reg[k] <= sp_next[k];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.res_real    = res_real_reg;
    assign result.res_imag    = res_imag_reg;
    assign result.saturated   = sat_reg;
    assign result.div_by_zero = dz_reg;
endmodule

>>> src/cau_checker.sv
// Port-level assertions for the complex arithmetic unit and their bind.
module cau_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [DATA_WIDTH-1:0] res_real,
    input logic signed [DATA_WIDTH-1:0] res_imag,
    input logic                         saturated,
    input logic                         div_by_zero
);
    localparam logic signed [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Operands are taken exactly when the output register can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("operand ready does not follow the output stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_real) && $stable(res_imag))
        else $error("stalled result changed");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> !saturated && res_real == '0 && res_imag == '0)
        else $error("divide by zero result is not a clean zero");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            res_real == VMAX || res_real == VMIN || res_imag == VMAX || res_imag == VMIN)
        else $error("saturated flag without a clipped component");
endmodule

bind complex_arithmetic_unit_top cau_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_cau_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (operand.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .res_real    (result.res_real),
    .res_imag    (result.res_imag),
    .saturated   (result.saturated),
    .div_by_zero (result.div_by_zero)
);
